// ===== rtl/core/dwr_pkg.sv =====
// dwr_pkg: shared types and constants for the draw-without-replacement unit.
// No dependencies; used by dwr_mod and draw_without_replacement_unit in rtl/core.
package dwr_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int RND_W = 31;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_BIG = 2'd2;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_REFILL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_result_t;

endpackage

// ===== rtl/core/dwr_ram.sv =====
// dwr_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module dwr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/dwr_mod.sv =====
// dwr_mod: bit-serial restoring modulo, 31-bit dividend by 7-bit divisor.
// Depends on dwr_pkg. One quotient bit per cycle.
module dwr_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dwr_pkg::RND_W-1:0] dividend,
    input  logic [dwr_pkg::CNT_W-1:0] divisor,
    output dwr_pkg::mod_result_t      result
);

    localparam int STEP_W = $clog2(dwr_pkg::RND_W);

    logic                      busy_reg, busy_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [dwr_pkg::RND_W-1:0] dvd_reg, dvd_next;
    logic [dwr_pkg::CNT_W-1:0] div_reg, div_next;
    logic [dwr_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [dwr_pkg::CNT_W:0]   trial;
    logic                      last_step;

    assign trial = {rem_reg, dvd_reg[dwr_pkg::RND_W-1]};
    assign last_step = busy_reg && (step_reg == STEP_W'(dwr_pkg::RND_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[dwr_pkg::RND_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = dwr_pkg::CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[dwr_pkg::CNT_W-1:0];
            end
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_step && !start;
        end
    end

    assign result.done = done_reg;
    assign result.remainder = rem_reg;

endmodule

// ===== rtl/core/draw_without_replacement_unit.sv =====
// draw_without_replacement_unit: top level, pool of indices drawn in random order.
// Depends on dwr_pkg, dwr_ram and dwr_mod.
//
// Usage:
//   Input stream (s_*): s_tuser carries the command (0 draw, 1 refill then draw),
//   s_tdata carries size and a 31-bit random word. Each input transfer yields
//   exactly one output transfer on m_*: drawn index and remaining count in
//   m_tdata, status (0 ok, 1 empty, 2 size too big) in m_tuser.
//   One item is processed at a time. A draw passes the empty check, the
//   bit-serial modulo (one bit per cycle), the pool RAM read and write-back and
//   the output load before m_tvalid rises. A refill of n entries first writes
//   them one at a time, since the pool RAM has one write port. An oversized
//   refill goes straight to the output load; a draw from an empty pool or a
//   refill of zero answers after the empty check. The next input is taken in
//   the cycle after the result is loaded.
//   The result sits in an output register; a new input is accepted while it
//   waits, and the next result holds in the unit until the receiver takes the
//   previous one. Reset empties the pool (live count zero); pool RAM content is
//   not cleared and needs no clearing pass.
module draw_without_replacement_unit #(
    parameter int POOL_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // size[6:0], random_word[37:7], zero pad
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // drawn_index[5:0], remaining[12:6], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int IDX_W = dwr_pkg::IDX_W;
    localparam int CNT_W = dwr_pkg::CNT_W;
    localparam int RND_W = dwr_pkg::RND_W;
    localparam int STAT_W = dwr_pkg::STAT_W;

    dwr_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [CNT_W-1:0]  res_rem_reg, res_rem_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    logic              in_xfer;
    logic              out_load;
    logic              in_cmd;
    logic [CNT_W-1:0]  in_size;
    logic [RND_W-1:0]  in_rnd;
    logic              size_too_big;
    logic [CNT_W-1:0]  last_slot;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [IDX_W-1:0]  mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_a;
    logic [IDX_W-1:0]  mem_rd_b;

    logic                 mod_start;
    dwr_pkg::mod_result_t mod_res;

    assign in_cmd = s_tuser[0];
    assign in_size = s_tdata[6:0];
    assign in_rnd = s_tdata[37:7];
    assign size_too_big = 32'(in_size) > 32'(POOL_DEPTH);
    assign in_xfer = s_tvalid && s_tready;
    assign last_slot = count_reg - CNT_W'(1);
    assign out_load = (state_reg == dwr_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    dwr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (AW'(slot_reg)),
        .rd_addr_b (AW'(last_slot)),
        .rd_data_a (mem_rd_a),
        .rd_data_b (mem_rd_b)
    );

    dwr_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rnd_reg),
        .divisor  (count_reg),
        .result   (mod_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dwr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_cmd == dwr_pkg::CMD_REFILL)
                    begin
                        state_next = size_too_big ? dwr_pkg::ST_DONE : dwr_pkg::ST_FILL;
                    end
                    else
                    begin
                        state_next = dwr_pkg::ST_CHECK;
                    end
                end
            end
            dwr_pkg::ST_FILL:
            begin
                if (fill_reg == count_reg)
                begin
                    state_next = dwr_pkg::ST_CHECK;
                end
            end
            dwr_pkg::ST_CHECK:
            begin
                state_next = (count_reg == '0) ? dwr_pkg::ST_DONE : dwr_pkg::ST_DIV;
            end
            dwr_pkg::ST_DIV:
            begin
                if (mod_res.done)
                begin
                    state_next = dwr_pkg::ST_READ;
                end
            end
            dwr_pkg::ST_READ:  state_next = dwr_pkg::ST_WRITE;
            dwr_pkg::ST_WRITE: state_next = dwr_pkg::ST_DONE;
            dwr_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = dwr_pkg::ST_IDLE;
                end
            end
            default: state_next = dwr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_tready      = (state_reg == dwr_pkg::ST_IDLE);
        count_next    = count_reg;
        fill_next     = fill_reg;
        rnd_next      = rnd_reg;
        slot_next     = slot_reg;
        res_idx_next  = res_idx_reg;
        res_stat_next = res_stat_reg;
        res_rem_next  = res_rem_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = AW'(fill_reg);
        mem_wr_data   = fill_reg[IDX_W-1:0];
        mod_start     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            dwr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rnd_next  = in_rnd;
                    fill_next = '0;
                    if (in_cmd == dwr_pkg::CMD_REFILL)
                    begin
                        if (size_too_big)
                        begin
                            res_idx_next  = '0;
                            res_stat_next = dwr_pkg::STAT_TOO_BIG;
                            res_rem_next  = count_reg;
                        end
                        else
                        begin
                            count_next = in_size;
                        end
                    end
                end
            end
            dwr_pkg::ST_FILL:
            begin
                if (fill_reg != count_reg)
                begin
                    mem_wr_en = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            dwr_pkg::ST_CHECK:
            begin
                if (count_reg == '0)
                begin
                    res_idx_next  = '0;
                    res_stat_next = dwr_pkg::STAT_EMPTY;
                    res_rem_next  = '0;
                end
                else
                begin
                    mod_start = 1'b1;
                end
            end
            dwr_pkg::ST_DIV:
            begin
                if (mod_res.done)
                begin
                    slot_next = mod_res.remainder;
                end
            end
            dwr_pkg::ST_READ:
            begin
            end
            dwr_pkg::ST_WRITE:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = AW'(slot_reg);
                mem_wr_data   = mem_rd_b;
                count_next    = last_slot;
                res_idx_next  = mem_rd_a;
                res_stat_next = dwr_pkg::STAT_OK;
                res_rem_next  = last_slot;
            end
            dwr_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_rem_reg, res_idx_reg};
                    m_tuser_next  = res_stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dwr_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg     <= fill_next;
        rnd_reg      <= rnd_next;
        slot_reg     <= slot_next;
        res_idx_reg  <= res_idx_next;
        res_stat_reg <= res_stat_next;
        res_rem_reg  <= res_rem_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // live count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(POOL_DEPTH))
        else $error("live count above pool depth");

    // chosen slot lies below the live count it was reduced by
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_res.done |-> (mod_res.remainder < count_reg))
        else $error("modulo result out of range");

    // a successful draw leaves fewer entries than the pool holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == dwr_pkg::STAT_OK) |-> (32'(m_tdata[12:6]) < 32'(POOL_DEPTH)))
        else $error("ok result with full pool remaining");

    // a draw consumes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dwr_pkg::ST_WRITE) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("live count not decremented on draw");

endmodule
